// ----- sv/bbc_pkg.sv -----
// Shared types and command codes for the block buffer cache controller.
// Used by every module of the block; depends on nothing else.
package bbc_pkg;

  localparam int CMD_W  = 3;
  localparam int ID_W   = 32;
  localparam int SLOT_W = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUFFER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SAVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  block_id;
  } bbc_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fetch;
    logic              writeback;
    logic [SLOT_W-1:0] writeback_slot;
    logic [ID_W-1:0]   writeback_block;
    logic              last;
  } bbc_out_t;

endpackage

// ----- sv/bbc_slot_store.sv -----
// Slot block-id store with registered read and the shared id comparator.
// Depends on bbc_pkg for the id width.
module bbc_slot_store #(
  parameter int NSLOT = 8,
  parameter int SW    = 3
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [SW-1:0]        widx,
  input  logic [bbc_pkg::ID_W-1:0] wdata,
  input  logic [SW-1:0]        ridx,
  input  logic [bbc_pkg::ID_W-1:0] key,
  output logic [bbc_pkg::ID_W-1:0] rd_data,
  output logic                 rd_eq
);
  import bbc_pkg::*;

  logic [ID_W-1:0] mem [NSLOT];
  logic [ID_W-1:0] rd_data_r;

  // Write one entry, read one entry each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    rd_data_r <= mem[ridx];
  end

  // Shared compare against the requested id
  assign rd_data = rd_data_r;
  assign rd_eq   = (rd_data_r == key);

endmodule

// ----- sv/bbc_seq.sv -----
// Sequencer: slot maps, current slot, scan counter and command dispatch.
// Depends on bbc_pkg; drives the slot store and the result beat.
module bbc_seq #(
  parameter int NSLOT = 8,
  parameter int SW    = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [bbc_pkg::CMD_W-1:0] cmd,
  input  logic                      out_free,
  input  logic [bbc_pkg::ID_W-1:0]  rd_data,
  input  logic                      rd_eq,
  output logic                      busy,
  output logic                      mem_we,
  output logic [SW-1:0]             mem_widx,
  output logic [SW-1:0]             mem_ridx,
  output logic                      res_valid,
  output bbc_pkg::bbc_out_t         res
);
  import bbc_pkg::*;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_LOOK = 2'd1;
  localparam logic [ST_W-1:0] ST_PICK = 2'd2;
  localparam logic [ST_W-1:0] ST_SAVE = 2'd3;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [NSLOT-1:0] assigned_r, assigned_nxt;
  logic [NSLOT-1:0] dirty_r, dirty_nxt;
  logic [SW-1:0]    cur_slot_r, cur_slot_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             free_found_r, free_found_nxt;
  logic [SW-1:0]    free_idx_r, free_idx_nxt;
  logic             clean_found_r, clean_found_nxt;
  logic [SW-1:0]    clean_idx_r, clean_idx_nxt;

  logic             last_idx;
  logic [NSLOT-1:0] ad;
  logic             higher;
  logic [SW-1:0]    pick_idx;
  logic             evict;

  assign last_idx = (idx_r == SW'(NSLOT - 1));
  assign ad       = assigned_r & dirty_r;

  // Any dirty slot above the scan position
  always_comb begin
    higher = 1'b0;
    for (int j = 0; j < NSLOT; j++) begin
      if ((j > int'(idx_r)) && ad[j]) begin
        higher = 1'b1;
      end
    end
  end

  // Miss victim: first free slot, else first clean slot, else slot 0
  always_comb begin
    evict = 1'b0;
    if (free_found_r) begin
      pick_idx = free_idx_r;
    end else if (clean_found_r) begin
      pick_idx = clean_idx_r;
    end else begin
      pick_idx = '0;
      evict    = 1'b1;
    end
  end

  // Command sequencer
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    assigned_nxt    = assigned_r;
    dirty_nxt       = dirty_r;
    cur_slot_nxt    = cur_slot_r;
    cur_valid_nxt   = cur_valid_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    clean_found_nxt = clean_found_r;
    clean_idx_nxt   = clean_idx_r;
    mem_we          = 1'b0;
    mem_widx        = pick_idx;
    res_valid       = 1'b0;
    res             = '0;

    case (state_r)
      ST_IDLE: begin
        if (go) begin
          case (cmd)
            CMD_BLOCK, CMD_BUFFER: begin
              state_nxt       = ST_LOOK;
              idx_nxt         = '0;
              free_found_nxt  = 1'b0;
              clean_found_nxt = 1'b0;
            end
            CMD_UPDATE: begin
              if (cur_valid_r) begin
                dirty_nxt[cur_slot_r] = 1'b1;
              end
            end
            CMD_SAVE, CMD_FLUSH: begin
              state_nxt = ST_SAVE;
              idx_nxt   = '0;
            end
            CMD_EMPTY: begin
              assigned_nxt  = '0;
              dirty_nxt     = '0;
              cur_slot_nxt  = '0;
              cur_valid_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (assigned_r[idx_r] && rd_eq) begin
          // Hit: report and hold until the output stage takes it
          if (out_free) begin
            res_valid     = 1'b1;
            res.slot      = SLOT_W'(idx_r);
            res.hit       = 1'b1;
            res.last      = 1'b1;
            cur_slot_nxt  = idx_r;
            cur_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          if (!assigned_r[idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (!dirty_r[idx_r] && !clean_found_r) begin
            clean_found_nxt = 1'b1;
            clean_idx_nxt   = idx_r;
          end
          if (last_idx) begin
            // Read slot 0 for a possible eviction
            state_nxt = ST_PICK;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_PICK: begin
        if (out_free) begin
          mem_we                 = 1'b1;
          assigned_nxt[pick_idx] = 1'b1;
          if (evict) begin
            dirty_nxt[0] = 1'b0;
          end
          cur_slot_nxt        = pick_idx;
          cur_valid_nxt       = 1'b1;
          res_valid           = 1'b1;
          res.slot            = SLOT_W'(pick_idx);
          res.fetch           = (cmd == CMD_BLOCK);
          res.writeback       = evict;
          res.writeback_block = evict ? rd_data : '0;
          res.last            = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      ST_SAVE: begin
        if (!ad[idx_r] || out_free) begin
          if (ad[idx_r]) begin
            res_valid           = 1'b1;
            res.writeback       = 1'b1;
            res.writeback_slot  = SLOT_W'(idx_r);
            res.writeback_block = rd_data;
            res.last            = !higher;
          end
          if (last_idx) begin
            dirty_nxt = '0;
            if (cmd == CMD_FLUSH) begin
              assigned_nxt  = '0;
              cur_slot_nxt  = '0;
              cur_valid_nxt = 1'b0;
            end
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Read one slot ahead so the registered data lines up with idx_r
  assign mem_ridx = idx_nxt;
  assign busy     = (state_r != ST_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      assigned_r    <= '0;
      dirty_r       <= '0;
      cur_slot_r    <= '0;
      cur_valid_r   <= 1'b0;
      free_found_r  <= 1'b0;
      clean_found_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      assigned_r    <= assigned_nxt;
      dirty_r       <= dirty_nxt;
      cur_slot_r    <= cur_slot_nxt;
      cur_valid_r   <= cur_valid_nxt;
      free_found_r  <= free_found_nxt;
      clean_found_r <= clean_found_nxt;
    end
  end

  // Scan bookkeeping payload
  always_ff @(posedge clk) begin
    free_idx_r  <= free_idx_nxt;
    clean_idx_r <= clean_idx_nxt;
  end

endmodule

// ----- sv/block_buffer_cache_controller.sv -----
// BLOCK/BUFFER: accept, a dispatch step, then a scan over the slots on the shared id
// comparator (SLOTS held to 1..8); a hit puts its beat out from the scan, a miss adds a
// pick step that puts it out; the next command is accepted once the sequencer is idle again.
// SAVE/FLUSH: dispatch plus a scan over the slots, one beat per dirty slot; UPDATE/EMPTY finish
// in the dispatch step; a stalled result beat holds the sequencer. Synchronous active-low reset clears
// the slot maps and current slot; the id store has no reset, unassigned ids are never read.
module block_buffer_cache_controller #(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbc_pkg::bbc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bbc_pkg::bbc_out_t out_data
);
  import bbc_pkg::*;

  localparam int NSLOT = (SLOTS > 8) ? 8 : ((SLOTS < 1) ? 1 : SLOTS);
  localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  bbc_in_t  req_r;
  logic     go_r;
  logic     busy;
  logic     out_free;
  logic     res_valid;
  bbc_out_t res;
  logic     out_valid_r;
  bbc_out_t out_data_r;

  logic            mem_we;
  logic [SW-1:0]   mem_widx;
  logic [SW-1:0]   mem_ridx;
  logic [ID_W-1:0] rd_data;
  logic            rd_eq;

  assign in_ready = !go_r && !busy;
  assign out_free = !out_valid_r || out_ready;

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= in_valid && in_ready;
    end
  end

  bbc_slot_store #(
    .NSLOT (NSLOT),
    .SW    (SW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .widx    (mem_widx),
    .wdata   (req_r.block_id),
    .ridx    (mem_ridx),
    .key     (req_r.block_id),
    .rd_data (rd_data),
    .rd_eq   (rd_eq)
  );

  bbc_seq #(
    .NSLOT (NSLOT),
    .SW    (SW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go_r),
    .cmd       (req_r.command),
    .out_free  (out_free),
    .rd_data   (rd_data),
    .rd_eq     (rd_eq),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_widx  (mem_widx),
    .mem_ridx  (mem_ridx),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a new beat or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/bbc_checker.sv -----
// Port-level checks for the block buffer cache controller, bound to the top level.
// Depends on bbc_pkg for the beat types.
module bbc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input bbc_pkg::bbc_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input bbc_pkg::bbc_out_t out_data
);
  import bbc_pkg::*;

  // One command at a time: ready drops right after an accepted beat
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted command");

  // Waiting command beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
    else $error("command beat changed while waiting");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while stalled");

  // A hit never fetches or writes back, and ends its command
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      (!out_data.fetch && !out_data.writeback && out_data.last))
    else $error("hit beat carries fetch or write-back");

  // Non-final beats come only from a save sweep
  a_save_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |->
      (out_data.writeback && !out_data.hit && !out_data.fetch && (out_data.slot == '0)))
    else $error("non-final beat is not a save write-back");

endmodule

bind block_buffer_cache_controller bbc_checker u_bbc_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for block_buffer_cache_controller: directed and random command beats,
// with a cache mirror that predicts each result beat and checks it field by field.
// Depends on bbc_pkg (sv/bbc_pkg.sv) and the controller RTL.
module tb;
  import bbc_pkg::*;

  localparam int SLOTS = 8;
  localparam int NSLOT = (SLOTS > 8) ? 8 : ((SLOTS < 1) ? 1 : SLOTS);
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS = 100;
  // Codes outside the defined command set; the controller must ignore them
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // Mirror of the slot maps; predicts the result beats of each accepted command
  class cache_mirror;
    logic [ID_W-1:0]   slot_ids [8];
    logic [7:0]        assigned;
    logic [7:0]        dirty;
    logic [SLOT_W-1:0] cur_slot;
    bit                cur_ok;
    bbc_out_t          due_replies [$];
    int                errors;

    function new();
      assigned = '0;
      dirty    = '0;
      cur_slot = '0;
      cur_ok   = 1'b0;
      errors   = 0;
      foreach (slot_ids[i]) slot_ids[i] = '0;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    // Find the block, or place it: free slot, then clean slot, then evict slot 0
    function void place_block(logic [ID_W-1:0] bid, bit with_fetch);
      bbc_out_t r;
      int pick;
      bit found;
      r = '0;
      r.last = 1'b1;
      pick = 0;
      found = 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!found && assigned[i] && slot_ids[i] == bid) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.slot = pick[SLOT_W-1:0];
        r.hit  = 1'b1;
      end else begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && !assigned[i]) begin
            pick = i;
            found = 1'b1;
          end
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && !dirty[i]) begin
            pick = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          pick = 0;
          r.writeback       = 1'b1;
          r.writeback_block = slot_ids[0];
          dirty[0] = 1'b0;
        end
        slot_ids[pick] = bid;
        assigned[pick] = 1'b1;
        r.slot  = pick[SLOT_W-1:0];
        r.fetch = with_fetch;
      end
      cur_slot = pick[SLOT_W-1:0];
      cur_ok   = 1'b1;
      due_replies.push_back(r);
    endfunction

    // One write-back beat per dirty slot, lowest first; the highest carries last
    function void write_back_dirty();
      bbc_out_t held;
      bit have;
      have = 1'b0;
      held = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (assigned[i] && dirty[i]) begin
          if (have) due_replies.push_back(held);
          held = '0;
          held.writeback       = 1'b1;
          held.writeback_slot  = i[SLOT_W-1:0];
          held.writeback_block = slot_ids[i];
          have = 1'b1;
        end
      end
      if (have) begin
        held.last = 1'b1;
        due_replies.push_back(held);
      end
      dirty = '0;
    endfunction

    function void track_command(bbc_in_t beat);
      case (beat.command)
        CMD_BLOCK:  place_block(beat.block_id, 1'b1);
        CMD_BUFFER: place_block(beat.block_id, 1'b0);
        CMD_UPDATE: begin
          if (cur_ok) dirty[cur_slot] = 1'b1;
        end
        CMD_SAVE:   write_back_dirty();
        CMD_FLUSH: begin
          write_back_dirty();
          assigned = '0;
          cur_ok   = 1'b0;
          cur_slot = '0;
        end
        CMD_EMPTY: begin
          assigned = '0;
          dirty    = '0;
          cur_ok   = 1'b0;
          cur_slot = '0;
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(bbc_out_t got);
      bbc_out_t want;
      if (due_replies.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      cmp_field("slot", 32'(want.slot), 32'(got.slot));
      cmp_field("hit", 32'(want.hit), 32'(got.hit));
      cmp_field("fetch", 32'(want.fetch), 32'(got.fetch));
      cmp_field("writeback", 32'(want.writeback), 32'(got.writeback));
      cmp_field("writeback_slot", 32'(want.writeback_slot), 32'(got.writeback_slot));
      cmp_field("writeback_block", want.writeback_block, got.writeback_block);
      cmp_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bbc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bbc_out_t out_data;

  cache_mirror mirror = new();
  int unsigned cycles = 0;
  int ready_left = 0;
  bit burst = 1'b0;
  logic [ID_W-1:0] id_pool [12];

  block_buffer_cache_controller #(.SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Watch both channels at every edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) mirror.track_command(in_data);
    if (rst_n && out_valid && out_ready) mirror.match_reply(out_data);
  end

  // Stall the result channel in random stretches
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left <= pick_gap();
    end else begin
      out_ready  <= 1'b1;
      ready_left <= $urandom_range(0, 25);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one command beat, hold it until accepted, then maybe idle
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] bid);
    bbc_in_t beat;
    int gap;
    beat.command  = cmd;
    beat.block_id = bid;
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower valid and hold off until every expected beat has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() > 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  initial begin
    int sent;
    int run_len;
    bit drained;
    logic [CMD_W-1:0] cmd;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    sent      = 0;
    drained   = 1'b0;
    foreach (id_pool[i]) id_pool[i] = (i < 6) ? $urandom_range(1, 20) : $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored commands, empty save, hit, fill, all dirty, evict, flush, empty
    send_cmd(CMD_UPDATE, 32'd0);
    send_cmd(CMD_SAVE, 32'd0);
    send_cmd(CMD_RSVD6, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD7, 32'h5A5A_A5A5);
    send_cmd(CMD_BLOCK, 32'd0);
    send_cmd(CMD_BLOCK, 32'd0);
    send_cmd(CMD_BUFFER, 32'hFFFF_FFFF);
    send_cmd(CMD_UPDATE, 32'd0);
    for (int i = 2; i < NSLOT; i++) begin
      send_cmd(CMD_BLOCK, i);
      send_cmd(CMD_UPDATE, 32'd0);
    end
    send_cmd(CMD_BUFFER, 32'd0);
    send_cmd(CMD_UPDATE, 32'd0);
    send_cmd(CMD_BLOCK, 32'h8000_0001);
    send_cmd(CMD_FLUSH, 32'd0);
    send_cmd(CMD_EMPTY, 32'd0);

    // Random: runs of lookups with updates, noise beats, closed by save/flush/empty
    while (sent < ITEMS) begin
      run_len = $urandom_range(6, 16);
      burst = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd = CMD_W'($urandom_range(0, 7));
          send_cmd(cmd, $urandom);
          if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7) sent++;
        end else begin
          send_cmd($urandom_range(0, 1) ? CMD_BLOCK : CMD_BUFFER, pick_id());
          sent++;
          if ($urandom_range(0, 9) < 6) begin
            send_cmd(CMD_UPDATE, $urandom);
            sent++;
          end
        end
      end
      case ($urandom_range(0, 4))
        0: send_cmd(CMD_SAVE, $urandom);
        1: send_cmd(CMD_FLUSH, $urandom);
        2: send_cmd(CMD_EMPTY, $urandom);
        default: ;
      endcase
      sent++;
      if (!drained && sent >= 50) begin
        drain();
        drained = 1'b1;
      end
    end
    burst = 1'b0;

    // Wait out the last results and any trailing command still in the scan
    drain();
    repeat (4 * NSLOT + 16) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
